FILE: src/mmm_pkg.sv
package mmm_pkg;

  localparam int MAX_DIM_DEF    = 8;
  localparam int DATA_WIDTH_DEF = 16;
  localparam int QUEUE_DEPTH    = 4;

  localparam int FUNC_W  = 2;
  localparam int IDX_W   = 3;
  localparam int DIM_W   = 4;
  localparam int VALUE_W = 16;
  localparam int PROD_W  = 40;
  localparam int CFG_IDX_W = 2;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_LOAD_A  = 2'd0,
    FUNC_LOAD_B  = 2'd1,
    FUNC_COMPUTE = 2'd2,
    FUNC_NONE    = 2'd3
  } func_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ROWS_A    = 2'd0,
    REG_INNER_DIM = 2'd1,
    REG_COLS_B    = 2'd2,
    REG_NONE      = 2'd3
  } cfg_reg_t;

  typedef enum logic [1:0] {
    OP_LOAD_A,
    OP_LOAD_B,
    OP_COMPUTE
  } op_t;

  typedef struct packed {
    op_t                op;
    logic [IDX_W-1:0]   row;
    logic [IDX_W-1:0]   col;
    logic [VALUE_W-1:0] value;
  } cmd_t;

  typedef struct packed {
    logic [DIM_W-1:0] m;
    logic [DIM_W-1:0] n;
    logic [DIM_W-1:0] p;
  } dims_t;

  typedef struct packed {
    logic             first;
    logic             lastk;
    logic             lastel;
    logic [IDX_W-1:0] row;
    logic [IDX_W-1:0] col;
  } meta_t;

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } bk_state_t;

  function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] v,
                                               input logic [DIM_W-1:0] max_dim);
    logic [DIM_W-1:0] r;
    if (v == '0) begin
      r = DIM_W'(1);
    end else if (v > max_dim) begin
      r = max_dim;
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

FILE: src/mmm_ram.sv
module mmm_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: src/mmm_front.sv
module mmm_front
  import mmm_pkg::*;
#(
  parameter int MAX_DIM = MAX_DIM_DEF
) (
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [FUNC_W-1:0]  in_func,
  input  logic [IDX_W-1:0]   in_row,
  input  logic [IDX_W-1:0]   in_col,
  input  logic [VALUE_W-1:0] in_value,
  output logic               push_valid,
  input  logic               push_stall,
  output cmd_t               push_cmd
);

  logic in_range;
  logic keep;

  assign in_range = ({1'b0, in_row} < (IDX_W+1)'(MAX_DIM)) &&
                    ({1'b0, in_col} < (IDX_W+1)'(MAX_DIM));

  always_comb begin
    keep           = 1'b0;
    push_cmd.op    = OP_COMPUTE;
    push_cmd.row   = in_row;
    push_cmd.col   = in_col;
    push_cmd.value = in_value;
    case (func_t'(in_func))
      FUNC_LOAD_A: begin
        keep        = in_range;
        push_cmd.op = OP_LOAD_A;
      end
      FUNC_LOAD_B: begin
        keep        = in_range;
        push_cmd.op = OP_LOAD_B;
      end
      FUNC_COMPUTE: begin
        keep        = 1'b1;
        push_cmd.op = OP_COMPUTE;
      end
      default: begin
        keep = 1'b0;
      end
    endcase
  end

  // dropped beats are still consumed, so stall just follows the queue
  assign in_stall   = push_stall;
  assign push_valid = in_valid && keep;

endmodule

FILE: src/mmm_queue.sv
module mmm_queue
  import mmm_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH,
  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int CW = $clog2(DEPTH + 1)
) (
  input  logic clk,
  input  logic rst_n,
  input  logic push_valid,
  output logic push_stall,
  input  cmd_t push_cmd,
  output logic pop_valid,
  input  logic pop,
  output cmd_t pop_cmd
);

  cmd_t          mem_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          do_push;

  assign push_stall = (count_r == CW'(DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_cmd    = mem_r[rd_ptr_r];
  assign do_push    = push_valid && !push_stall;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (!do_push && pop) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

FILE: src/mmm_back.sv
module mmm_back
  import mmm_pkg::*;
#(
  parameter int MAX_DIM    = MAX_DIM_DEF,
  parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  dims_t             dims,
  input  logic              q_valid,
  input  cmd_t              q_cmd,
  output logic              q_pop,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [IDX_W-1:0]  out_row,
  output logic [IDX_W-1:0]  out_col,
  output logic [PROD_W-1:0] out_product,
  output logic              out_last
);

  localparam int DEPTH = MAX_DIM * MAX_DIM;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int MUL_W = 2 * DATA_WIDTH;
  localparam int ACC_W = MUL_W + 3;
  localparam int EXT_W = (ACC_W > PROD_W) ? ACC_W : PROD_W;
  localparam int HI_W  = EXT_W - PROD_W + 1;

  bk_state_t state_r, state_nxt;
  logic [IDX_W-1:0] i_r, i_nxt;
  logic [IDX_W-1:0] j_r, j_nxt;
  logic [IDX_W-1:0] k_r, k_nxt;

  logic en;
  logic issue;
  logic last_k, last_j, last_i;
  logic we_a, we_b;
  logic [AW-1:0] waddr;
  logic [DATA_WIDTH-1:0] wdata;
  logic [AW-1:0] raddr_a, raddr_b;
  logic [DATA_WIDTH-1:0] rd_a, rd_b;

  meta_t meta_issue;
  logic  v1_r, v2_r;
  meta_t meta1_r, meta2_r;
  logic signed [MUL_W-1:0] prod_r;
  logic signed [ACC_W-1:0] acc_r;
  logic signed [ACC_W-1:0] acc_base;
  logic signed [ACC_W-1:0] sum;
  logic [EXT_W-1:0] ext;
  logic [HI_W-1:0]  hi;
  logic [PROD_W-1:0] sat;

  logic out_valid_r;
  logic [IDX_W-1:0]  out_row_r;
  logic [IDX_W-1:0]  out_col_r;
  logic [PROD_W-1:0] out_product_r;
  logic              out_last_r;

  // compute datapath freezes while a result waits on a stalled output
  assign en = !out_valid_r || !out_stall;

  assign last_k = ({1'b0, k_r} == dims.n - 1'b1);
  assign last_j = ({1'b0, j_r} == dims.p - 1'b1);
  assign last_i = ({1'b0, i_r} == dims.m - 1'b1);

  always_comb begin
    state_nxt = state_r;
    i_nxt     = i_r;
    j_nxt     = j_r;
    k_nxt     = k_r;
    case (state_r)
      ST_IDLE: begin
        if (q_valid && q_cmd.op == OP_COMPUTE) begin
          state_nxt = ST_RUN;
          i_nxt     = '0;
          j_nxt     = '0;
          k_nxt     = '0;
        end
      end
      ST_RUN: begin
        if (en) begin
          if (!last_k) begin
            k_nxt = k_r + 1'b1;
          end else begin
            k_nxt = '0;
            if (!last_j) begin
              j_nxt = j_r + 1'b1;
            end else begin
              j_nxt = '0;
              if (!last_i) begin
                i_nxt = i_r + 1'b1;
              end else begin
                state_nxt = ST_IDLE;
              end
            end
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    q_pop = 1'b0;
    issue = 1'b0;
    we_a  = 1'b0;
    we_b  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        q_pop = q_valid;
        we_a  = q_valid && q_cmd.op == OP_LOAD_A;
        we_b  = q_valid && q_cmd.op == OP_LOAD_B;
      end
      ST_RUN: begin
        issue = en;
      end
      default: begin
        q_pop = 1'b0;
      end
    endcase
  end

  assign waddr   = AW'(int'(q_cmd.row) * MAX_DIM + int'(q_cmd.col));
  assign wdata   = DATA_WIDTH'(q_cmd.value);
  assign raddr_a = AW'(int'(i_r) * MAX_DIM + int'(k_r));
  assign raddr_b = AW'(int'(k_r) * MAX_DIM + int'(j_r));

  mmm_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (DEPTH)
  ) u_ram_a (
    .clk   (clk),
    .we    (we_a),
    .waddr (waddr),
    .wdata (wdata),
    .re    (en),
    .raddr (raddr_a),
    .rdata (rd_a)
  );

  mmm_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (DEPTH)
  ) u_ram_b (
    .clk   (clk),
    .we    (we_b),
    .waddr (waddr),
    .wdata (wdata),
    .re    (en),
    .raddr (raddr_b),
    .rdata (rd_b)
  );

  always_comb begin
    meta_issue.first  = (k_r == '0);
    meta_issue.lastk  = last_k;
    meta_issue.lastel = last_i && last_j;
    meta_issue.row    = i_r;
    meta_issue.col    = j_r;
  end

  assign acc_base = meta2_r.first ? '0 : acc_r;
  assign sum      = acc_base + ACC_W'(prod_r);
  assign ext      = EXT_W'(sum);
  assign hi       = ext[EXT_W-1:PROD_W-1];

  always_comb begin
    if ((&hi) || !(|hi)) begin
      sat = ext[PROD_W-1:0];
    end else if (ext[EXT_W-1]) begin
      sat = {1'b1, {(PROD_W-1){1'b0}}};
    end else begin
      sat = {1'b0, {(PROD_W-1){1'b1}}};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      i_r         <= '0;
      j_r         <= '0;
      k_r         <= '0;
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      i_r     <= i_nxt;
      j_r     <= j_nxt;
      k_r     <= k_nxt;
      if (en) begin
        v1_r        <= issue;
        v2_r        <= v1_r;
        out_valid_r <= v2_r && meta2_r.lastk;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      meta1_r <= meta_issue;
      meta2_r <= meta1_r;
      prod_r  <= $signed(rd_a) * $signed(rd_b);
      if (v2_r) begin
        acc_r <= sum;
      end
      if (v2_r && meta2_r.lastk) begin
        out_row_r     <= meta2_r.row;
        out_col_r     <= meta2_r.col;
        out_product_r <= sat;
        out_last_r    <= meta2_r.lastel;
      end
    end
  end

  assign out_valid   = out_valid_r;
  assign out_row     = out_row_r;
  assign out_col     = out_col_r;
  assign out_product = out_product_r;
  assign out_last    = out_last_r;

endmodule

FILE: src/matrix_matrix_multiply.sv
// Matrix multiply R = A * B on signed Q8.8 elements, results in signed Q24.16
// (40 bits, exact). Load beats (func 0 for A, 1 for B) write one element each
// and are retired from the queue while no compute beat runs; a compute beat
// streams out every element of R in row-major order with out_last on the
// final one. Input beats go through a 4-entry command queue, so in_stall
// rises only when that queue is full. A compute beat issues rows_a * cols_b *
// inner_dim products (up to 512) to the single multiply-accumulate unit fed
// from the two element RAMs, one product per cycle while the output does not
// stall. A stalled output freezes the multiply-accumulate pipeline. Dimension
// registers read 0 as 1 and clamp above MAX_DIM; loads with row or col at or
// above MAX_DIM and func code 3 are consumed and dropped. Reading an element
// that was never loaded gives an undefined result.
module matrix_matrix_multiply
  import mmm_pkg::*;
#(
  parameter int MAX_DIM    = MAX_DIM_DEF,
  parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [DIM_W-1:0]     cfg_data,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [FUNC_W-1:0]    in_func,
  input  logic [IDX_W-1:0]     in_row,
  input  logic [IDX_W-1:0]     in_col,
  input  logic signed [VALUE_W-1:0] in_value,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [IDX_W-1:0]     out_row,
  output logic [IDX_W-1:0]     out_col,
  output logic signed [PROD_W-1:0] out_product,
  output logic                 out_last
);

  logic [DIM_W-1:0] rows_a_r, inner_dim_r, cols_b_r;
  dims_t dims;

  logic push_valid, push_stall;
  cmd_t push_cmd;
  logic q_valid, q_pop;
  cmd_t q_cmd;
  logic [PROD_W-1:0] product;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_a_r    <= DIM_W'(MAX_DIM);
      inner_dim_r <= DIM_W'(MAX_DIM);
      cols_b_r    <= DIM_W'(MAX_DIM);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_reg_t'(cfg_index))
        REG_ROWS_A:    rows_a_r    <= cfg_data;
        REG_INNER_DIM: inner_dim_r <= cfg_data;
        REG_COLS_B:    cols_b_r    <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    dims.m = eff_dim(rows_a_r, DIM_W'(MAX_DIM));
    dims.n = eff_dim(inner_dim_r, DIM_W'(MAX_DIM));
    dims.p = eff_dim(cols_b_r, DIM_W'(MAX_DIM));
  end

  mmm_front #(
    .MAX_DIM (MAX_DIM)
  ) u_front (
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_func    (in_func),
    .in_row     (in_row),
    .in_col     (in_col),
    .in_value   (in_value),
    .push_valid (push_valid),
    .push_stall (push_stall),
    .push_cmd   (push_cmd)
  );

  mmm_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_stall (push_stall),
    .push_cmd   (push_cmd),
    .pop_valid  (q_valid),
    .pop        (q_pop),
    .pop_cmd    (q_cmd)
  );

  mmm_back #(
    .MAX_DIM    (MAX_DIM),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .dims        (dims),
    .q_valid     (q_valid),
    .q_cmd       (q_cmd),
    .q_pop       (q_pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_row     (out_row),
    .out_col     (out_col),
    .out_product (product),
    .out_last    (out_last)
  );

  assign out_product = product;

endmodule
